// ===== hw/rtl/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, constants and the crc-8 step for the rc-channels frame parser.
// ----------------------------------------------------------------------------
package crsf_pkg;

    localparam int PAYLOAD_BYTES = 22;
    localparam int NUM_CHANNELS  = 16;
    localparam int CHANNEL_BITS  = 11;
    localparam int FRAME_LEN     = PAYLOAD_BYTES + 2;
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES + 1);
    localparam int CH_W          = $clog2(NUM_CHANNELS);
    localparam int BUF_W         = 24;
    localparam int FILL_W        = $clog2(BUF_W + 1);

    localparam logic [7:0] CRC_POLY      = 8'hD5;
    localparam logic [7:0] FRAME_TYPE_RC = 8'h16;
    localparam logic [7:0] BROADCAST     = 8'h00;

    // configuration register indexes
    localparam logic CFG_ADDR = 1'b0;
    localparam logic CFG_CRC  = 1'b1;

    // parse phases, one-hot
    typedef enum logic [4:0] {
        PH_ADDR    = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_TYPE    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CRC     = 5'b10000
    } t_phase;

    // payload store write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // unpacker status toward the parser
    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] rd_ptr;
    } t_stat;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/crsf_unpack.sv =====
// ----------------------------------------------------------------------------
// crsf_unpack
// Payload store and channel unpacker: reads the stored payload one byte a
// cycle into a bit buffer while that buffer has room, and emits 11-bit channels lsb-first.
// ----------------------------------------------------------------------------
module crsf_unpack (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  crsf_pkg::t_wr          i_wr,
    input  logic                   i_start,
    input  logic                   i_out_ready,
    output crsf_pkg::t_stat        o_stat,
    output logic                   o_valid,
    output logic [crsf_pkg::CH_W-1:0] o_index,
    output logic [crsf_pkg::CHANNEL_BITS-1:0] o_value,
    output logic                   o_last
);

    // payload memory
    logic [7:0] r_mem [crsf_pkg::PAYLOAD_BYTES];
    logic [7:0] r_rd_data;
    logic       r_rd_valid;

    logic                          r_busy;
    logic [crsf_pkg::ADDR_W-1:0]   r_rd_ptr;
    logic [crsf_pkg::BUF_W-1:0]    r_bits;
    logic [crsf_pkg::FILL_W-1:0]   r_fill;
    logic [crsf_pkg::CH_W-1:0]     r_ch;
    logic                          r_valid;
    logic [crsf_pkg::CH_W-1:0]     r_index;
    logic [crsf_pkg::CHANNEL_BITS-1:0] r_value;
    logic                          r_last;

    logic                          can_emit;
    logic                          rd_en;
    logic                          ch_last;
    logic [crsf_pkg::BUF_W-1:0]    bits_1;
    logic [crsf_pkg::FILL_W-1:0]   fill_1;
    logic [crsf_pkg::BUF_W-1:0]    n_bits;
    logic [crsf_pkg::FILL_W-1:0]   n_fill;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // emit when a whole channel is buffered and the output slot is free
    assign can_emit = r_busy &&
                      (r_fill >= crsf_pkg::FILL_W'(crsf_pkg::CHANNEL_BITS)) &&
                      (!r_valid || i_out_ready);
    assign ch_last  = (r_ch == crsf_pkg::CH_W'(crsf_pkg::NUM_CHANNELS - 1));

    // consume then append the byte that comes back from memory
    always_comb begin
        bits_1 = can_emit ? (r_bits >> crsf_pkg::CHANNEL_BITS) : r_bits;
        fill_1 = can_emit ? (r_fill - crsf_pkg::FILL_W'(crsf_pkg::CHANNEL_BITS)) : r_fill;
        n_bits = bits_1;
        n_fill = fill_1;
        if (r_rd_valid) begin
            n_bits = bits_1 | (crsf_pkg::BUF_W'(r_rd_data) << fill_1);
            n_fill = fill_1 + crsf_pkg::FILL_W'(8);
        end
    end

    // next read only when the buffer has room for it
    assign rd_en = r_busy && (r_rd_ptr < crsf_pkg::ADDR_W'(crsf_pkg::PAYLOAD_BYTES)) &&
                   (n_fill <= crsf_pkg::FILL_W'(crsf_pkg::BUF_W - 8));

    // unpack sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rd_ptr   <= '0;
            r_rd_valid <= 1'b0;
            r_fill     <= '0;
            r_ch       <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_rd_valid <= rd_en;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_rd_ptr <= '0;
                r_fill   <= '0;
                r_ch     <= '0;
            end else begin
                r_fill <= n_fill;
                if (rd_en) begin
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end
                if (can_emit) begin
                    r_ch <= r_ch + 1'b1;
                    if (ch_last) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (can_emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload of the buffer and output register
    always_ff @(posedge i_clk) begin
        r_bits <= i_start ? '0 : n_bits;
        if (can_emit) begin
            r_index <= r_ch;
            r_value <= r_bits[crsf_pkg::CHANNEL_BITS-1:0];
            r_last  <= ch_last;
        end
    end

    assign o_stat.busy   = r_busy;
    assign o_stat.rd_ptr = r_rd_ptr;
    assign o_valid       = r_valid;
    assign o_index       = r_index;
    assign o_value       = r_value;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/crsf_rc_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crsf_rc_frame_parser
// Recognizes rc-channels frames in a received byte stream and emits the
// sixteen unpacked 11-bit channels of each good frame.
// ----------------------------------------------------------------------------
// Channel items follow the taken crc byte through the registered payload memory read,
// the unpack bit buffer and the output register; reads are held back while the
// unpack bit buffer is near full.
// Throughput: one byte item per cycle; payload and crc bytes of the next frame
// wait while they would catch up with the read-out of the previous one.
// Reset (synchronous, active low): address hunting, address 0xC8, crc check on.
module crsf_rc_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // channel output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] channel_index, [14:4] channel_value, [15] zero
    output logic        m_axis_tlast    // last
);

    logic [7:0]                  r_addr_cfg;
    logic                        r_crc_en;
    crsf_pkg::t_phase            r_phase;
    crsf_pkg::t_phase            n_phase;
    logic [crsf_pkg::ADDR_W-1:0] r_count;
    logic [crsf_pkg::ADDR_W-1:0] n_count;
    logic [7:0]                  r_crc;
    logic [7:0]                  n_crc;

    crsf_pkg::t_wr               wr;
    crsf_pkg::t_stat             stat;
    logic                        start;
    logic                        accept;
    logic                        stall;
    logic [7:0]                  rx;
    logic [crsf_pkg::CH_W-1:0]   out_index;
    logic [crsf_pkg::CHANNEL_BITS-1:0] out_value;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_cfg <= 8'hC8;
            r_crc_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crsf_pkg::CFG_ADDR: r_addr_cfg <= i_cfg_data;
                crsf_pkg::CFG_CRC:  r_crc_en   <= i_cfg_data[0];
                default:            r_addr_cfg <= r_addr_cfg;
            endcase
        end
    end

    // hold payload and crc bytes that would overtake the channel read-out
    assign stall = stat.busy &&
                   ((r_phase == crsf_pkg::PH_PAYLOAD && r_count >= stat.rd_ptr) ||
                    r_phase == crsf_pkg::PH_CRC);
    assign s_axis_tready = !stall;
    assign accept        = s_axis_tvalid && !stall;
    assign rx            = s_axis_tdata;

    // frame parser
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_crc    = r_crc;
        wr.en    = 1'b0;
        wr.addr  = r_count;
        wr.data  = rx;
        start    = 1'b0;
        if (accept) begin
            case (r_phase)
                crsf_pkg::PH_LEN: begin
                    n_phase = (rx == 8'(crsf_pkg::FRAME_LEN)) ? crsf_pkg::PH_TYPE
                                                              : crsf_pkg::PH_ADDR;
                end
                crsf_pkg::PH_TYPE: begin
                    if (rx == crsf_pkg::FRAME_TYPE_RC) begin
                        n_count = '0;
                        n_crc   = crsf_pkg::crc_update(8'h00, rx);
                        n_phase = crsf_pkg::PH_PAYLOAD;
                    end else begin
                        n_phase = crsf_pkg::PH_ADDR;
                    end
                end
                crsf_pkg::PH_PAYLOAD: begin
                    wr.en   = 1'b1;
                    n_crc   = crsf_pkg::crc_update(r_crc, rx);
                    n_count = r_count + 1'b1;
                    if (n_count >= crsf_pkg::ADDR_W'(crsf_pkg::PAYLOAD_BYTES)) begin
                        n_phase = crsf_pkg::PH_CRC;
                    end
                end
                crsf_pkg::PH_CRC: begin
                    start   = !r_crc_en || (rx == r_crc);
                    n_phase = crsf_pkg::PH_ADDR;
                end
                default: begin
                    n_phase = (rx == r_addr_cfg || rx == crsf_pkg::BROADCAST) ?
                              crsf_pkg::PH_LEN : crsf_pkg::PH_ADDR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= crsf_pkg::PH_ADDR;
            r_count <= '0;
            r_crc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // payload store and channel unpacker
    crsf_unpack u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_start     (start),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_valid     (m_axis_tvalid),
        .o_index     (out_index),
        .o_value     (out_value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_value, out_index};

endmodule
